>>> src/cfws_pkg.sv
// cfws_pkg: shared constants, operation codes, controller states and the
// command/status structs between the controller and the datapath.
// No dependencies.
`default_nettype none

package cfws_pkg;

    // queue geometry
    localparam int DEPTH   = 8;
    localparam int AW      = $clog2(DEPTH);
    localparam int CW      = $clog2(DEPTH + 1);

    // field widths
    localparam int DATA_W  = 32;
    localparam int FUNC_W  = 2;
    localparam int COUNT_W = 4;
    localparam int MEAN_W  = 40;
    localparam int FRAC_W  = 8;

    // statistics arithmetic: sum never wraps, scaled magnitude feeds the divider
    localparam int SUM_W     = DATA_W + 1 + $clog2(DEPTH);
    localparam int MAG_W     = SUM_W - 1 + FRAC_W;
    localparam int DIV_RADIX = 4;
    localparam int DIV_STEPS = (MAG_W + DIV_RADIX - 1) / DIV_RADIX;
    localparam int DVW       = DIV_STEPS * DIV_RADIX;
    localparam int RW        = CW + 1;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // operation codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH  = 2'd0,
        FUNC_POP   = 2'd1,
        FUNC_PEEK  = 2'd2,
        FUNC_STATS = 2'd3
    } func_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_HEAD,
        ST_WALK,
        ST_DIV_INIT,
        ST_DIV,
        ST_DIV_FIN,
        ST_DONE
    } cfws_state_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic push;
        logic take_head;
        logic walk_start;
        logic walk_step;
        logic div_init;
        logic div_step;
        logic div_fin;
        logic emit;
    } cfws_cmd_t;

    // datapath to controller
    typedef struct packed {
        func_t func;
        logic  empty;
        logic  full;
        logic  walk_last;
        logic  div_done;
        logic  rsp_busy;
    } cfws_status_t;

endpackage

`default_nettype wire

>>> src/cfws_ram.sv
// cfws_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cfws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> src/cfws_ctrl.sv
// cfws_ctrl: controller state machine that sequences one item at a time.
// Depends on cfws_pkg.
`default_nettype none

module cfws_ctrl
    import cfws_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         req_valid,
    output logic              req_stall,
    input  wire cfws_status_t status,
    output cfws_cmd_t         cmd
);

    cfws_state_t state_reg;
    cfws_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                state_next = ST_DONE;
                case (status.func)
                    FUNC_PUSH:
                    begin
                        if (!status.full)
                        begin
                            cmd.push = 1'b1;
                        end
                    end
                    FUNC_POP, FUNC_PEEK:
                    begin
                        if (!status.empty)
                        begin
                            state_next = ST_HEAD;
                        end
                    end
                    FUNC_STATS:
                    begin
                        if (!status.empty)
                        begin
                            cmd.walk_start = 1'b1;
                            state_next     = ST_WALK;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_HEAD:
            begin
                cmd.take_head = 1'b1;
                state_next    = ST_DONE;
            end
            ST_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (status.walk_last)
                begin
                    state_next = ST_DIV_INIT;
                end
            end
            ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = ST_DIV_FIN;
                end
            end
            ST_DIV_FIN:
            begin
                cmd.div_fin = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (!status.rsp_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/cfws_dp.sv
// cfws_dp: datapath with the slot RAM, pointers, statistics accumulators,
// the radix-16 divider for the mean and the result register.
// Depends on cfws_pkg and cfws_ram.
`default_nettype none

module cfws_dp
    import cfws_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [FUNC_W-1:0]         func,
    input  wire logic signed [DATA_W-1:0]  data_in,
    input  wire cfws_cmd_t                 cmd,
    output cfws_status_t                   status,
    input  wire logic                      rsp_stall,
    output logic                           rsp_valid,
    output logic                           ok,
    output logic signed [DATA_W-1:0]       data_out,
    output logic [COUNT_W-1:0]             count,
    output logic signed [DATA_W-1:0]       largest,
    output logic signed [DATA_W-1:0]       smallest,
    output logic signed [MEAN_W-1:0]       mean_q8
);

    // control registers
    logic [AW-1:0]     head_reg, head_next;
    logic [AW-1:0]     tail_reg, tail_next;
    logic [CW-1:0]     fill_reg, fill_next;
    logic [CW-1:0]     walk_cnt_reg, walk_cnt_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              rsp_valid_reg, rsp_valid_next;

    // payload registers
    func_t                     func_reg, func_next;
    logic [DATA_W-1:0]         word_reg, word_next;
    logic [AW-1:0]             walk_idx_reg, walk_idx_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic signed [DATA_W-1:0]  max_reg, max_next;
    logic signed [DATA_W-1:0]  min_reg, min_next;
    logic [DVW-1:0]            dvd_reg, dvd_next;
    logic [RW-1:0]             rem_reg, rem_next;
    logic                      neg_reg, neg_next;
    logic                      ok_reg, ok_next;
    logic [DATA_W-1:0]         dout_reg, dout_next;
    logic signed [DATA_W-1:0]  big_reg, big_next;
    logic signed [DATA_W-1:0]  small_reg, small_next;
    logic signed [MEAN_W-1:0]  mean_reg, mean_next;
    logic                      rsp_ok_reg, rsp_ok_next;
    logic [DATA_W-1:0]         rsp_dout_reg, rsp_dout_next;
    logic [COUNT_W-1:0]        rsp_count_reg, rsp_count_next;
    logic signed [DATA_W-1:0]  rsp_big_reg, rsp_big_next;
    logic signed [DATA_W-1:0]  rsp_small_reg, rsp_small_next;
    logic signed [MEAN_W-1:0]  rsp_mean_reg, rsp_mean_next;

    // ram ports
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    // arithmetic helpers
    logic signed [DATA_W-1:0] rd_val;
    logic signed [SUM_W-1:0]  rd_ext;
    logic [SUM_W-1:0]         sum_mag;
    logic [DVW-1:0]           quo_neg;
    logic [RW-1:0]            div_r;
    logic [DVW-1:0]           div_d;

    // wrap a ring pointer at the queue depth
    function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
        logic [AW-1:0] n;
        if (p == AW'(DEPTH - 1))
        begin
            n = '0;
        end
        else
        begin
            n = p + AW'(1);
        end
        return n;
    endfunction

    // slot storage
    cfws_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (tail_reg),
        .wdata (word_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_raddr = cmd.walk_step ? walk_idx_reg : head_reg;

    assign rd_val  = $signed(ram_rdata);
    assign rd_ext  = SUM_W'(rd_val);
    assign sum_mag = sum_reg[SUM_W-1] ? (SUM_W'(~sum_reg) + SUM_W'(1)) : SUM_W'(sum_reg);
    assign quo_neg = ~dvd_reg + DVW'(1);

    // one radix-16 step of the restoring divider, divisor is the fill count
    always_comb
    begin
        div_r = rem_reg;
        div_d = dvd_reg;
        for (int i = 0; i < DIV_RADIX; i++)
        begin
            div_r = {div_r[RW-2:0], div_d[DVW-1]};
            div_d = {div_d[DVW-2:0], 1'b0};
            if (div_r >= RW'(fill_reg))
            begin
                div_r    = div_r - RW'(fill_reg);
                div_d[0] = 1'b1;
            end
        end
    end

    // status to the controller
    always_comb
    begin
        status.func      = func_reg;
        status.empty     = (fill_reg == '0);
        status.full      = (fill_reg == CW'(DEPTH));
        status.walk_last = (walk_cnt_reg == fill_reg - CW'(1));
        status.div_done  = (step_reg == STEP_W'(DIV_STEPS - 1));
        status.rsp_busy  = rsp_valid_reg && rsp_stall;
    end

    // next-state logic
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        fill_next      = fill_reg;
        walk_cnt_next  = walk_cnt_reg;
        step_next      = step_reg;
        func_next      = func_reg;
        word_next      = word_reg;
        walk_idx_next  = walk_idx_reg;
        sum_next       = sum_reg;
        max_next       = max_reg;
        min_next       = min_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        neg_next       = neg_reg;
        ok_next        = ok_reg;
        dout_next      = dout_reg;
        big_next       = big_reg;
        small_next     = small_reg;
        mean_next      = mean_reg;
        rsp_ok_next    = rsp_ok_reg;
        rsp_dout_next  = rsp_dout_reg;
        rsp_count_next = rsp_count_reg;
        rsp_big_next   = rsp_big_reg;
        rsp_small_next = rsp_small_reg;
        rsp_mean_next  = rsp_mean_reg;
        rsp_valid_next = rsp_valid_reg;

        // capture item and clear the working result
        if (cmd.load_item)
        begin
            func_next  = func_t'(func);
            word_next  = data_in;
            ok_next    = 1'b0;
            dout_next  = '0;
            big_next   = '0;
            small_next = '0;
            mean_next  = '0;
        end

        // push into the tail slot
        if (cmd.push)
        begin
            tail_next = next_ptr(tail_reg);
            fill_next = fill_reg + CW'(1);
            ok_next   = 1'b1;
        end

        // pop or peek the head slot
        if (cmd.take_head)
        begin
            dout_next = ram_rdata;
            ok_next   = 1'b1;
            if (func_reg == FUNC_POP)
            begin
                head_next = next_ptr(head_reg);
                fill_next = fill_reg - CW'(1);
            end
        end

        // statistics walk from head
        if (cmd.walk_start)
        begin
            walk_idx_next = next_ptr(head_reg);
            walk_cnt_next = '0;
        end

        if (cmd.walk_step)
        begin
            walk_idx_next = next_ptr(walk_idx_reg);
            walk_cnt_next = walk_cnt_reg + CW'(1);
            if (walk_cnt_reg == '0)
            begin
                sum_next = rd_ext;
                max_next = rd_val;
                min_next = rd_val;
            end
            else
            begin
                sum_next = sum_reg + rd_ext;
                if (rd_val > max_reg)
                begin
                    max_next = rd_val;
                end
                if (rd_val < min_reg)
                begin
                    min_next = rd_val;
                end
            end
        end

        // mean: divide the scaled magnitude, then restore the sign
        if (cmd.div_init)
        begin
            dvd_next  = DVW'({sum_mag[SUM_W-2:0], {FRAC_W{1'b0}}});
            rem_next  = '0;
            neg_next  = sum_reg[SUM_W-1];
            step_next = '0;
        end

        if (cmd.div_step)
        begin
            dvd_next  = div_d;
            rem_next  = div_r;
            step_next = step_reg + STEP_W'(1);
        end

        if (cmd.div_fin)
        begin
            mean_next  = neg_reg ? MEAN_W'(quo_neg) : MEAN_W'(dvd_reg);
            big_next   = max_reg;
            small_next = min_reg;
            ok_next    = 1'b1;
        end

        // result register
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        if (cmd.emit)
        begin
            rsp_valid_next = 1'b1;
            rsp_ok_next    = ok_reg;
            rsp_dout_next  = dout_reg;
            rsp_count_next = COUNT_W'(fill_reg);
            rsp_big_next   = big_reg;
            rsp_small_next = small_reg;
            rsp_mean_next  = mean_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            walk_cnt_reg  <= '0;
            step_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            walk_cnt_reg  <= walk_cnt_next;
            step_reg      <= step_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        word_reg      <= word_next;
        walk_idx_reg  <= walk_idx_next;
        sum_reg       <= sum_next;
        max_reg       <= max_next;
        min_reg       <= min_next;
        dvd_reg       <= dvd_next;
        rem_reg       <= rem_next;
        neg_reg       <= neg_next;
        ok_reg        <= ok_next;
        dout_reg      <= dout_next;
        big_reg       <= big_next;
        small_reg     <= small_next;
        mean_reg      <= mean_next;
        rsp_ok_reg    <= rsp_ok_next;
        rsp_dout_reg  <= rsp_dout_next;
        rsp_count_reg <= rsp_count_next;
        rsp_big_reg   <= rsp_big_next;
        rsp_small_reg <= rsp_small_next;
        rsp_mean_reg  <= rsp_mean_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign ok        = rsp_ok_reg;
    assign data_out  = $signed(rsp_dout_reg);
    assign count     = rsp_count_reg;
    assign largest   = rsp_big_reg;
    assign smallest  = rsp_small_reg;
    assign mean_q8   = rsp_mean_reg;

endmodule

`default_nettype wire

>>> src/circular_fifo_with_stats_top.sv
// circular_fifo_with_stats_top: ring-buffer queue of signed words with statistics.
// Usage notes follow; depends on cfws_pkg, cfws_ctrl and cfws_dp.
//
// Request channel (req_valid/req_stall, func, data_in): one operation per transfer,
// push, pop, peek or statistics. Response channel (rsp_valid/rsp_stall): exactly
// one result per request, in order, with ok, data_out, count (entries held after
// the operation), largest, smallest and mean_q8 (signed, 8 fraction bits).
// Fields that do not apply to an operation, or to a refused one, read zero.
// Requests are handled one at a time; req_stall is high from the transfer until
// the result has been moved into the response register.
// Push and refused operations go from dispatch straight to the response; pop and peek
// add a head read; statistics read one slot per cycle over the held entries,
// then run an 11-step radix-16 divide by the count for the mean.
// A new request is taken the cycle after the previous result is loaded, so a
// waiting response does not hold back the next operation; a stalled response
// holds its payload, and the next result waits until it has been taken.
// Reset empties the queue (head, tail and count to zero) and drops any response;
// slot contents are not cleared and are read only after being written.
`default_nettype none

module circular_fifo_with_stats_top
    import cfws_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      req_valid,
    output logic                           req_stall,
    input  wire logic [FUNC_W-1:0]         func,
    input  wire logic signed [DATA_W-1:0]  data_in,
    output logic                           rsp_valid,
    input  wire logic                      rsp_stall,
    output logic                           ok,
    output logic signed [DATA_W-1:0]       data_out,
    output logic [COUNT_W-1:0]             count,
    output logic signed [DATA_W-1:0]       largest,
    output logic signed [DATA_W-1:0]       smallest,
    output logic signed [MEAN_W-1:0]       mean_q8
);

    cfws_cmd_t    cmd;
    cfws_status_t status;

    // sequencing
    cfws_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // storage, arithmetic and response register
    cfws_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .func      (func),
        .data_in   (data_in),
        .cmd       (cmd),
        .status    (status),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .ok        (ok),
        .data_out  (data_out),
        .count     (count),
        .largest   (largest),
        .smallest  (smallest),
        .mean_q8   (mean_q8)
    );

endmodule

`default_nettype wire

>>> bench/tb_circular_fifo_with_stats_top.sv
// tb_circular_fifo_with_stats_top: self-checking bench for the ring-buffer queue with statistics
// drives push/pop/peek/stats transfers, tracks the queue contents itself and checks every result
// depends on cfws_pkg and circular_fifo_with_stats_top

module tb_circular_fifo_with_stats_top;
    import cfws_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 4;
    localparam int RANDOM_OPS    = 450;
    localparam int PHASE_LEN     = 56;
    localparam int IDLE_PCT      = 52;
    localparam int BOTH_IDLE_PCT = 30;
    localparam int HOLD_AT       = 60;
    localparam int HOLD_CYCLES   = 150;
    localparam int SETTLE_CYCLES = 40;
    localparam int QUIET_LIMIT   = 2000;

    typedef enum logic [1:0] {
        GAPS_NONE,
        GAPS_SENDER,
        GAPS_RECEIVER,
        GAPS_BOTH
    } gap_mode_t;

    typedef struct {
        func_t                    op;
        logic signed [DATA_W-1:0] word;
        gap_mode_t                gaps;
    } fifo_op_t;

    typedef struct {
        logic                     ok;
        logic signed [DATA_W-1:0] data_out;
        logic [COUNT_W-1:0]       count;
        logic signed [DATA_W-1:0] largest;
        logic signed [DATA_W-1:0] smallest;
        logic signed [MEAN_W-1:0] mean_q8;
    } fifo_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      req_valid = 1'b0;
    logic                      req_stall;
    logic [FUNC_W-1:0]         func = '0;
    logic signed [DATA_W-1:0]  data_in = '0;
    logic                      rsp_valid;
    logic                      rsp_stall = 1'b0;
    logic                      ok;
    logic signed [DATA_W-1:0]  data_out;
    logic [COUNT_W-1:0]        count;
    logic signed [DATA_W-1:0]  largest;
    logic signed [DATA_W-1:0]  smallest;
    logic signed [MEAN_W-1:0]  mean_q8;

    fifo_op_t     ops_to_send[$];
    fifo_result_t fifo_results_due[$];
    gap_mode_t    cur_gaps = GAPS_NONE;
    bit           req_fire = 1'b0;
    int unsigned  requests_taken = 0;
    int unsigned  mismatches = 0;
    int unsigned  quiet_cycles = 0;
    int           hold_left = 0;
    bit           hold_done = 1'b0;

    // bench copy of the queue contents
    logic signed [DATA_W-1:0] ring [DEPTH];
    int                       head = 0;
    int                       tail = 0;
    int                       held = 0;

    circular_fifo_with_stats_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .func      (func),
        .data_in   (data_in),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .ok        (ok),
        .data_out  (data_out),
        .count     (count),
        .largest   (largest),
        .smallest  (smallest),
        .mean_q8   (mean_q8)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // apply one operation to the bench queue and return the result it must give
    function automatic fifo_result_t compute_fifo_result(func_t op,
                                                         logic signed [DATA_W-1:0] word);
        fifo_result_t             r;
        logic signed [DATA_W-1:0] v;
        logic signed [DATA_W-1:0] hi;
        logic signed [DATA_W-1:0] lo;
        longint                   total;
        int                       idx;
        r = '{default: '0};
        case (op)
            FUNC_PUSH:
            begin
                if (held < DEPTH)
                begin
                    ring[tail] = word;
                    tail = (tail + 1) % DEPTH;
                    held++;
                    r.ok = 1'b1;
                end
            end
            FUNC_POP, FUNC_PEEK:
            begin
                if (held != 0)
                begin
                    r.data_out = ring[head];
                    if (op == FUNC_POP)
                    begin
                        head = (head + 1) % DEPTH;
                        held--;
                    end
                    r.ok = 1'b1;
                end
            end
            default:
            begin
                // walk head to tail, the mean truncates toward zero
                if (held != 0)
                begin
                    idx = head;
                    hi = ring[idx];
                    lo = hi;
                    total = 0;
                    for (int k = 0; k < held; k++)
                    begin
                        v = ring[idx];
                        if (v > hi) hi = v;
                        if (v < lo) lo = v;
                        total += longint'(v);
                        idx = (idx + 1) % DEPTH;
                    end
                    r.largest = hi;
                    r.smallest = lo;
                    r.mean_q8 = MEAN_W'((total * 256) / longint'(held));
                    r.ok = 1'b1;
                end
            end
        endcase
        r.count = held[COUNT_W-1:0];
        return r;
    endfunction

    function automatic bit takes_break(gap_mode_t gaps, bit sender);
        int pct;
        case (gaps)
            GAPS_SENDER:   pct = sender ? IDLE_PCT : 0;
            GAPS_RECEIVER: pct = sender ? 0 : IDLE_PCT;
            GAPS_BOTH:     pct = BOTH_IDLE_PCT;
            default:       pct = 0;
        endcase
        return $urandom_range(99) < pct;
    endfunction

    function automatic func_t random_op(int push_pct);
        func_t op;
        if ($urandom_range(99) < push_pct)
            op = FUNC_PUSH;
        else
        begin
            case ($urandom_range(3))
                0, 1:    op = FUNC_POP;
                2:       op = FUNC_PEEK;
                default: op = FUNC_STATS;
            endcase
        end
        return op;
    endfunction

    // extremes often, otherwise any word
    function automatic logic signed [DATA_W-1:0] random_word();
        logic signed [DATA_W-1:0] w;
        case ($urandom_range(7))
            0:       w = 32'sh8000_0000;
            1:       w = 32'sh7FFF_FFFF;
            2:       w = '0;
            3:       w = '1;
            default: w = $urandom;
        endcase
        return w;
    endfunction

    task automatic add_op(func_t op, logic signed [DATA_W-1:0] word, gap_mode_t gaps);
        fifo_op_t item;
        item.op = op;
        item.word = word;
        item.gaps = gaps;
        ops_to_send.push_back(item);
    endtask

    task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // request driver, a held payload stays put until its transfer
    always @(negedge clk)
    begin : drive_requests
        logic     next_valid;
        fifo_op_t item;
        if (rst_n && (!req_valid || req_fire))
        begin
            next_valid = 1'b0;
            if (ops_to_send.size() != 0 && !takes_break(ops_to_send[0].gaps, 1'b1))
            begin
                item = ops_to_send.pop_front();
                func <= item.op;
                data_in <= item.word;
                cur_gaps <= item.gaps;
                next_valid = 1'b1;
            end
            req_valid <= next_valid;
        end
    end

    // response stall, with one long hold-off so the block backs up
    always @(negedge clk)
    begin : drive_stall
        if (hold_left != 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else if (!hold_done && requests_taken >= HOLD_AT)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= takes_break(cur_gaps, 1'b0);
    end

    // monitor: queue a prediction per request transfer, check each response transfer
    always @(posedge clk)
    begin : watch_ports
        fifo_result_t want;
        if (rst_n)
        begin
            req_fire = req_valid && !req_stall;
            if (req_fire)
            begin
                fifo_results_due.push_back(compute_fifo_result(func_t'(func), data_in));
                requests_taken++;
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (fifo_results_due.size() == 0)
                begin
                    $display("%0t: result with nothing expected, ok %0b data_out %0d count %0d",
                             $time, ok, data_out, count);
                    mismatches++;
                end
                else
                begin
                    want = fifo_results_due.pop_front();
                    check_field("ok", 64'(want.ok), 64'(ok));
                    check_field("data_out", 64'(want.data_out), 64'(data_out));
                    check_field("count", 64'(want.count), 64'(count));
                    check_field("largest", 64'(want.largest), 64'(largest));
                    check_field("smallest", 64'(want.smallest), 64'(smallest));
                    check_field("mean_q8", 64'(want.mean_q8), 64'(mean_q8));
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin : watchdog
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin : run_test
        int burst_left;
        int push_pct;

        // refused operations on an empty queue
        add_op(FUNC_STATS, 32'sh1234_5678, GAPS_NONE);
        add_op(FUNC_POP, '1, GAPS_NONE);
        add_op(FUNC_PEEK, 32'sh8000_0000, GAPS_NONE);
        // extremes, then a mean that must truncate toward zero
        add_op(FUNC_PUSH, 32'sh7FFF_FFFF, GAPS_NONE);
        add_op(FUNC_PUSH, 32'sh8000_0000, GAPS_NONE);
        add_op(FUNC_PUSH, '1, GAPS_NONE);
        add_op(FUNC_STATS, '0, GAPS_NONE);
        // fill up, push when full, statistics over a full queue
        repeat (5) add_op(FUNC_PUSH, 32'sh7FFF_FFFF, GAPS_NONE);
        add_op(FUNC_PUSH, 32'sh5A5A_5A5A, GAPS_NONE);
        add_op(FUNC_STATS, '0, GAPS_NONE);
        add_op(FUNC_PEEK, '0, GAPS_NONE);
        // drain past empty
        repeat (DEPTH + 1) add_op(FUNC_POP, '0, GAPS_NONE);

        // random bursts that lean toward filling or draining
        burst_left = 0;
        push_pct = 50;
        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(20, 8);
                push_pct = $urandom_range(1) ? 75 : 30;
            end
            burst_left--;
            add_op(random_op(push_pct), random_word(), gap_mode_t'((i / PHASE_LEN) % 4));
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (ops_to_send.size() != 0 || req_valid || fifo_results_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> sim.f
src/cfws_pkg.sv
src/cfws_ram.sv
src/cfws_ctrl.sv
src/cfws_dp.sv
src/circular_fifo_with_stats_top.sv
bench/tb_circular_fifo_with_stats_top.sv
